FILE: hdl/orwd_pkg.sv
// shared types and constants for the overwrite ring with window dump
// no dependencies; used by the front queue, the back unit and the top level
`timescale 1ns / 1ps

package orwd_pkg;

  // fixed field widths
  localparam int ValueBits = 16;
  localparam int CapBits   = 6;

  // configuration port
  localparam int PaddrBits = 3;
  localparam int PdataBits = 32;
  localparam logic [CapBits-1:0] CapReset = 6'd63;

  // register index codes (paddr[2])
  localparam logic CFG_CAPACITY = 1'b0;

  // operation codes carried by an item
  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_GET  = 2'd1,
    KIND_DUMP = 2'd2
  } kind_e;

  // one queued item
  typedef struct packed {
    kind_e                kind;
    logic [ValueBits-1:0] value;
  } orwd_item_t;

endpackage

FILE: hdl/orwd_front.sv
// front part: takes items, drops unused operation codes, buffers the rest
// in a short queue for the back unit; depends on orwd_pkg
`timescale 1ns / 1ps

module orwd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         kind_i,
  input  logic [orwd_pkg::ValueBits-1:0]     value_i,
  output logic                               head_vld_o,
  output orwd_pkg::orwd_item_t               head_o,
  input  logic                               pop_i
);

  localparam int Depth   = 4;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  orwd_pkg::orwd_item_t  q_mem [Depth];
  logic [PtrBits-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  full;
  logic                  keep;
  logic                  push;
  logic                  pop;

  // classify the operation code
  always_comb begin
    unique case (kind_i) inside
      orwd_pkg::KIND_PUT, orwd_pkg::KIND_GET, orwd_pkg::KIND_DUMP: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign full       = (cnt_q == CntBits'(Depth));
  assign busy_o     = full;
  assign push       = start_i && !full && keep;
  assign head_vld_o = (cnt_q != '0);
  assign pop        = pop_i && head_vld_o;
  assign head_o     = q_mem[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrBits'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{kind: orwd_pkg::kind_e'(kind_i), value: value_i};
    end
  end

endmodule

FILE: hdl/orwd_back.sv
// back part: ring store, write/read indices, fill count and the dump sequencer
// depends on orwd_pkg; fed by orwd_front
`timescale 1ns / 1ps

module orwd_back #(
  parameter int MAX_CAPACITY = 63,
  parameter int WORD_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [orwd_pkg::CapBits-1:0]       capacity_i,
  input  logic                               head_vld_i,
  input  orwd_pkg::orwd_item_t               head_i,
  output logic                               pop_o,
  output logic                               res_strobe_o,
  output logic [orwd_pkg::ValueBits-1:0]     value_res_o,
  output logic                               last_o,
  output logic [orwd_pkg::CapBits-1:0]       filled_o
);

  localparam int SlotCount = MAX_CAPACITY + 1;
  localparam int IdxBits   = $clog2(SlotCount);
  localparam int CapBits   = orwd_pkg::CapBits;
  localparam int StoreBits = (WORD_BITS < orwd_pkg::ValueBits) ? WORD_BITS
                                                              : orwd_pkg::ValueBits;
  localparam logic [CapBits-1:0] MaxCap = CapBits'(MAX_CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e               state_q, state_d;
  logic [IdxBits-1:0]   wr_idx_q, wr_idx_d;
  logic [IdxBits-1:0]   rd_idx_q, rd_idx_d;
  logic [IdxBits-1:0]   fill_q, fill_d;
  logic [IdxBits-1:0]   dump_idx_q, dump_idx_d;
  logic [IdxBits-1:0]   remain_q, remain_d;
  logic [SlotCount-1:0] slot_vld_q;

  logic [StoreBits-1:0] ring_mem [SlotCount];
  logic [StoreBits-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic                 strobe_q;
  logic                 last_q;
  logic [CapBits-1:0]   filled_q;

  logic [CapBits-1:0]   cap;
  logic                 mem_we;
  logic                 rd_en;
  logic [IdxBits-1:0]   rd_addr;
  logic                 rd_last;

  // next slot, wrapping at the effective capacity
  function automatic logic [IdxBits-1:0] adv(input logic [IdxBits-1:0] idx,
                                             input logic [CapBits-1:0] lim);
    if (CapBits'(idx) >= lim) begin
      return '0;
    end
    return idx + IdxBits'(1);
  endfunction

  // capacity clamped to the store size
  assign cap   = (capacity_i > MaxCap) ? MaxCap : capacity_i;
  assign pop_o = (state_q == ST_IDLE);

  // operation decode and dump sequencing
  always_comb begin
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    fill_d     = fill_q;
    dump_idx_d = dump_idx_q;
    remain_d   = remain_q;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rd_idx_q;
    rd_last    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_vld_i) begin
          unique case (head_i.kind)
            orwd_pkg::KIND_PUT: begin
              mem_we   = 1'b1;
              wr_idx_d = adv(wr_idx_q, cap);
              if (CapBits'(fill_q) < cap) begin
                fill_d = fill_q + IdxBits'(1);
              end
            end
            orwd_pkg::KIND_GET: begin
              rd_en    = 1'b1;
              rd_last  = 1'b1;
              rd_idx_d = adv(rd_idx_q, cap);
            end
            orwd_pkg::KIND_DUMP: begin
              rd_idx_d = adv(rd_idx_q, cap);
              if (cap != '0) begin
                rd_en      = 1'b1;
                rd_last    = (cap == CapBits'(1));
                dump_idx_d = adv(rd_idx_q, cap);
                remain_d   = IdxBits'(cap - CapBits'(1));
                if (cap != CapBits'(1)) begin
                  state_d = ST_DUMP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        rd_en      = 1'b1;
        rd_addr    = dump_idx_q;
        rd_last    = (remain_q == IdxBits'(1));
        dump_idx_d = adv(dump_idx_q, cap);
        remain_d   = remain_q - IdxBits'(1);
        if (remain_q == IdxBits'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, indices, slot valid bits and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      fill_q     <= '0;
      dump_idx_q <= '0;
      remain_q   <= '0;
      slot_vld_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      fill_q     <= fill_d;
      dump_idx_q <= dump_idx_d;
      remain_q   <= remain_d;
      strobe_q   <= rd_en;
      if (mem_we) begin
        slot_vld_q[wr_idx_q] <= 1'b1;
      end
    end
  end

  // result payload, taken along with the read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_vld_q <= slot_vld_q[rd_addr];
      last_q   <= rd_last;
      filled_q <= CapBits'(fill_q);
    end
  end

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_idx_q] <= head_i.value[StoreBits-1:0];
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // a slot never written reads as zero
  assign res_strobe_o = strobe_q;
  assign value_res_o  = rd_vld_q ? orwd_pkg::ValueBits'(rd_data_q) : '0;
  assign last_o       = last_q;
  assign filled_o     = filled_q;

endmodule

FILE: hdl/overwrite_ring_with_window_dump.sv
// top level of the overwrite ring with window dump: capacity register and the
// front queue / back unit pair; depends on orwd_pkg, orwd_front, orwd_back
`timescale 1ns / 1ps

// The ring keeps capacity+1 words. Items enter through start/busy into a
// four-entry queue; busy is high only while that queue is full. The back unit
// takes one item per cycle while no dump runs; a dump reads capacity words
// (one ring read per cycle, single read port). An unused operation code is
// dropped at the front. A result is on the result ports for the cycle that
// follows the edge at which the back unit takes its item, with res_strobe_o
// high for exactly one cycle, so a get that finds the queue empty and the
// back unit idle passes the queue and then the result registers before its
// word shows; dump words come out on consecutive cycles. The receiver cannot
// stall the results. Reset clears the ring through per-slot valid bits, so the
// block takes items right after reset. Write capacity only while idle.

module overwrite_ring_with_window_dump #(
  parameter int MAX_CAPACITY = 63,
  parameter int WORD_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         kind_i,
  input  logic [orwd_pkg::ValueBits-1:0]     value_i,
  output logic                               res_strobe_o,
  output logic [orwd_pkg::ValueBits-1:0]     value_res_o,
  output logic                               last_o,
  output logic [orwd_pkg::CapBits-1:0]       filled_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [orwd_pkg::PaddrBits-1:0]     paddr,
  input  logic [orwd_pkg::PdataBits-1:0]     pwdata,
  output logic [orwd_pkg::PdataBits-1:0]     prdata,
  output logic                               pready
);

  logic [orwd_pkg::CapBits-1:0] capacity_q;
  logic                         cfg_we;
  logic                         head_vld;
  orwd_pkg::orwd_item_t         head;
  logic                         pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == orwd_pkg::CFG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= orwd_pkg::CapReset;
    end else if (cfg_we) begin
      capacity_q <= pwdata[orwd_pkg::CapBits-1:0];
    end
  end

  assign prdata = (paddr[2] == orwd_pkg::CFG_CAPACITY) ?
                  orwd_pkg::PdataBits'(capacity_q) : '0;

  // front queue
  orwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back unit
  orwd_back #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .head_vld_i   (head_vld),
    .head_i       (head),
    .pop_o        (pop),
    .res_strobe_o (res_strobe_o),
    .value_res_o  (value_res_o),
    .last_o       (last_o),
    .filled_o     (filled_o)
  );

endmodule

FILE: hdl/orwd_checker.sv
// port-level checks for the overwrite ring with window dump, bound to the top
// depends on orwd_pkg and overwrite_ring_with_window_dump
`timescale 1ns / 1ps

module orwd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               res_strobe_o,
  input logic                               last_o,
  input logic [orwd_pkg::CapBits-1:0]       filled_o
);

  // dump words come out back to back until the last one
  a_dump_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |=> res_strobe_o)
    else $error("dump word not followed by the next word");

  // the fill count cannot move during a dump
  a_dump_fill_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |=> $stable(filled_o))
    else $error("filled changed inside a dump");

  // the queue only fills through an item
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !res_strobe_o)
    else $error("result strobe right after reset");

endmodule

bind overwrite_ring_with_window_dump orwd_checker u_orwd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .last_o       (last_o),
  .filled_o     (filled_o)
);
